[rtl/core/fcpu_pkg.sv]
// ----------------------------------------------------------------------------
// fcpu_pkg
// Shared constants, types and elaboration-time trig tables for the fly
// camera pose update block.
// ----------------------------------------------------------------------------
package fcpu_pkg;

    localparam int POS_FRAC_BITS    = 16;
    localparam int DIR_FRAC_BITS    = 14;
    localparam int TRIG_TABLE_DEPTH = 1024;

    localparam int TRIG_IDX_W   = $clog2(TRIG_TABLE_DEPTH);
    localparam int TRIG_QUARTER = TRIG_TABLE_DEPTH / 4;
    localparam int TRIG_QTR_W   = TRIG_IDX_W - 2;
    localparam int TRIG_VAL_W   = 31;

    localparam int TURN_UNITS  = 46080;
    localparam int PITCH_LIMIT = 11392;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // angle to table index: floor(a * DEPTH / TURN_UNITS) by reciprocal multiply
    localparam int          IDX_SHIFT = 24;
    localparam longint      RECIP_MUL =
        ((longint'(TRIG_TABLE_DEPTH) << IDX_SHIFT) + TURN_UNITS - 1) / TURN_UNITS;

    // quotient bits of the shift-subtract divider
    localparam int DIV_Q_BITS = 20;
    localparam int DIV_CNT_W  = $clog2(DIV_Q_BITS);
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

    localparam logic CMD_ROTATE    = 1'b0;
    localparam logic CMD_TRANSLATE = 1'b1;

    localparam logic [2:0] AXIS_LEFT  = 3'd0;
    localparam logic [2:0] AXIS_RIGHT = 3'd1;
    localparam logic [2:0] AXIS_UP    = 3'd2;
    localparam logic [2:0] AXIS_DOWN  = 3'd3;
    localparam logic [2:0] AXIS_FRONT = 3'd4;
    localparam logic [2:0] AXIS_BACK  = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ROT_ANG,
        ST_ROT_YMUL,
        ST_ROT_PMUL,
        ST_ROT_PTRIG,
        ST_ROT_CPCY,
        ST_ROT_V2,
        ST_ROT_SQ1,
        ST_ROT_SQ2,
        ST_ROT_SQ3,
        ST_SIDE_SQ0,
        ST_SIDE_SQ1,
        ST_SIDE_SQ2,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_DONE,
        ST_MOVE_MUL,
        ST_MOVE_ADD,
        ST_UPDN,
        ST_OUT
    } state_t;

    function automatic logic [TRIG_QUARTER*TRIG_VAL_W-1:0] build_sin_tab();
        logic [TRIG_QUARTER*TRIG_VAL_W-1:0] tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] sn;
        logic [63:0] s0;
        tab = '0;
        for (int j = 0; j < TRIG_QUARTER; j++) begin
            x  = (64'(j) * 64'd4 * HALF_PI_Q30) / TRIG_TABLE_DEPTH;
            x2 = (x * x) >> 30;
            sn = ONE_Q30;
            sn = ONE_Q30 - ((x2 * sn) >> 30) / 110;
            sn = ONE_Q30 - ((x2 * sn) >> 30) / 72;
            sn = ONE_Q30 - ((x2 * sn) >> 30) / 42;
            sn = ONE_Q30 - ((x2 * sn) >> 30) / 20;
            sn = ONE_Q30 - ((x2 * sn) >> 30) / 6;
            s0 = (x * sn) >> 30;
            tab[j*TRIG_VAL_W +: TRIG_VAL_W] = s0[TRIG_VAL_W-1:0];
        end
        return tab;
    endfunction

    function automatic logic [TRIG_QUARTER*TRIG_VAL_W-1:0] build_cos_tab();
        logic [TRIG_QUARTER*TRIG_VAL_W-1:0] tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] cs;
        tab = '0;
        for (int j = 0; j < TRIG_QUARTER; j++) begin
            x  = (64'(j) * 64'd4 * HALF_PI_Q30) / TRIG_TABLE_DEPTH;
            x2 = (x * x) >> 30;
            cs = ONE_Q30;
            cs = ONE_Q30 - ((x2 * cs) >> 30) / 132;
            cs = ONE_Q30 - ((x2 * cs) >> 30) / 90;
            cs = ONE_Q30 - ((x2 * cs) >> 30) / 56;
            cs = ONE_Q30 - ((x2 * cs) >> 30) / 30;
            cs = ONE_Q30 - ((x2 * cs) >> 30) / 12;
            cs = ONE_Q30 - ((x2 * cs) >> 30) / 2;
            tab[j*TRIG_VAL_W +: TRIG_VAL_W] = cs[TRIG_VAL_W-1:0];
        end
        return tab;
    endfunction

    localparam logic [TRIG_QUARTER*TRIG_VAL_W-1:0] SIN_TAB = build_sin_tab();
    localparam logic [TRIG_QUARTER*TRIG_VAL_W-1:0] COS_TAB = build_cos_tab();

endpackage

[rtl/core/fly_camera_pose_update.sv]
// ----------------------------------------------------------------------------
// fly_camera_pose_update
// Camera pose keeper: rotates by yaw/pitch deltas and moves along six axes.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one command per transaction. s_tuser selects rotate
//   (0) or translate (1); s_tdata holds the deltas, axis and distance.
//   m_ channel returns the full pose after every command.
//   One command is handled at a time; s_tready is high only while idle.
//   From accept to m_tvalid the path runs through a shared 32x32 multiplier and one
//   shift-subtract unit that runs the 32-step square root and three 20-step
//   divisions:
//     rotate           multiplier, square root and divisions
//     left / right     as rotate, then the move; no divisions when view x and z are both zero
//     front / back     multiplier and add for each position component
//     up / down        a single add on pos_y
//     unused axis      straight to the result
//   Back to idle in the cycle after the result transaction.
//   The result holds in m_tdata while m_tready is low; no new command is
//   taken until the result is accepted.
//   Reset puts the camera at (0, 0, 10) looking down -z, yaw and pitch zero.
// ----------------------------------------------------------------------------
module fly_camera_pose_update (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // yaw_delta[15:0], pitch_delta[31:16], move_axis[34:32], move_distance[66:35]
    input  logic [71:0]  s_tdata,
    // command[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], view_x[111:96], view_y[127:112],
    // view_z[143:128], yaw_now[159:144], pitch_now[174:160]
    output logic [175:0] m_tdata
);
    import fcpu_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic                     cmd_reg;
    logic signed [15:0]       yd_reg;
    logic signed [15:0]       pd_reg;
    logic signed [31:0]       dist_reg;
    logic                     neg_reg;
    logic [1:0]               idx_reg;

    logic signed [31:0]       pos_reg  [3];
    logic signed [15:0]       view_reg [3];
    logic [15:0]              yaw_reg;
    logic signed [14:0]       pitch_reg;

    logic signed [31:0]       comp_reg [3];
    logic signed [31:0]       cp_reg;
    logic signed [31:0]       cy_reg;
    logic signed [63:0]       prod_reg;
    logic [63:0]              acc_reg;
    logic [63:0]              sq_v_reg;
    logic [63:0]              sq_res_reg;
    logic [63:0]              sq_bit_reg;
    logic [SQRT_CNT_W-1:0]    sq_cnt_reg;
    logic [63:0]              n_reg;
    logic [63:0]              dsh_reg;
    logic [DIV_Q_BITS-1:0]    q_reg;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;

    logic signed [31:0]       mul_a;
    logic signed [31:0]       mul_b;
    logic signed [63:0]       prod;

    logic [2:0]               s_axis;
    logic [TRIG_IDX_W-1:0]    trig_idx;
    logic [TRIG_QTR_W-1:0]    trig_r;
    logic signed [31:0]       s0;
    logic signed [31:0]       c0;
    logic signed [31:0]       trig_s;
    logic signed [31:0]       trig_c;

    logic signed [17:0]       yaw_sum;
    logic [15:0]              yaw_new;
    logic signed [16:0]       pitch_sum;
    logic signed [14:0]       pitch_new;
    logic signed [16:0]       pitch_wide;
    logic [15:0]              ua_pitch;

    logic [63:0]              sq_t;
    logic                     sq_ge;
    logic                     div_ge;
    logic [32:0]              comp_mag;
    logic [63:0]              num_mag;
    logic signed [15:0]       div_res;
    logic [63:0]              v2_mag;
    logic [63:0]              side_l2;
    logic [63:0]              p_mag;
    logic signed [63:0]       move_d;
    logic signed [63:0]       move_sum;
    logic signed [33:0]       updn_sum;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign s_axis = s_tdata[34:32];

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_ROT_YMUL: begin
                mul_a = 32'({16'b0, yaw_reg});
                mul_b = 32'(RECIP_MUL);
            end
            ST_ROT_PMUL: begin
                mul_a = 32'({16'b0, ua_pitch});
                mul_b = 32'(RECIP_MUL);
            end
            ST_ROT_CPCY: begin
                mul_a = cp_reg;
                mul_b = cy_reg;
            end
            ST_ROT_V2: begin
                mul_a = comp_reg[0];
                mul_b = comp_reg[0];
            end
            ST_ROT_SQ1: begin
                mul_a = comp_reg[1];
                mul_b = comp_reg[1];
            end
            ST_ROT_SQ2: begin
                mul_a = comp_reg[2];
                mul_b = comp_reg[2];
            end
            ST_SIDE_SQ0: begin
                mul_a = 32'(view_reg[0]);
                mul_b = 32'(view_reg[0]);
            end
            ST_SIDE_SQ1: begin
                mul_a = 32'(view_reg[2]);
                mul_b = 32'(view_reg[2]);
            end
            ST_MOVE_MUL: begin
                mul_a = comp_reg[idx_reg];
                mul_b = dist_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // table trig on the index left in prod_reg
    always_comb begin
        trig_idx = prod_reg[IDX_SHIFT +: TRIG_IDX_W];
        trig_r   = trig_idx[TRIG_QTR_W-1:0];
        s0 = 32'({1'b0, SIN_TAB[32'(trig_r)*TRIG_VAL_W +: TRIG_VAL_W]});
        c0 = 32'({1'b0, COS_TAB[32'(trig_r)*TRIG_VAL_W +: TRIG_VAL_W]});
        case (trig_idx[TRIG_IDX_W-1 -: 2])
            2'd0: begin
                trig_s = s0;
                trig_c = c0;
            end
            2'd1: begin
                trig_s = c0;
                trig_c = -s0;
            end
            2'd2: begin
                trig_s = -s0;
                trig_c = -c0;
            end
            default: begin
                trig_s = -c0;
                trig_c = s0;
            end
        endcase
    end

    // angle update, pitch wrap into table range
    always_comb begin
        yaw_sum = 18'(signed'({2'b0, yaw_reg})) + 18'(yd_reg);
        if (yaw_sum < 0) begin
            yaw_new = 16'(yaw_sum + 18'sd46080);
        end else if (yaw_sum >= 18'sd46080) begin
            yaw_new = 16'(yaw_sum - 18'sd46080);
        end else begin
            yaw_new = 16'(yaw_sum);
        end
        pitch_sum = 17'(pitch_reg) + 17'(pd_reg);
        if (pitch_sum > 17'sd11392) begin
            pitch_new = 15'sd11392;
        end else if (pitch_sum < -17'sd11392) begin
            pitch_new = -15'sd11392;
        end else begin
            pitch_new = 15'(pitch_sum);
        end
        pitch_wide = 17'(pitch_reg);
        ua_pitch = (pitch_wide < 0) ? 16'(pitch_wide + 17'sd46080) : 16'(pitch_wide);
    end

    // shift-subtract unit and small datapath terms
    always_comb begin
        sq_t     = sq_res_reg + sq_bit_reg;
        sq_ge    = (sq_v_reg >= sq_t);
        div_ge   = (n_reg >= dsh_reg);
        comp_mag = (comp_reg[idx_reg] < 0) ? 33'(-33'(comp_reg[idx_reg]))
                                           : 33'(comp_reg[idx_reg]);
        num_mag  = (cmd_reg == CMD_ROTATE) ? (64'(comp_mag) << DIR_FRAC_BITS)
                                           : (64'(comp_mag) << (DIR_FRAC_BITS + 8));
        if (comp_reg[idx_reg] < 0) begin
            div_res = (32'(q_reg) > 32'd32768) ? -16'sd32768 : 16'(-(32'(q_reg)));
        end else begin
            div_res = (32'(q_reg) > 32'd32767) ? 16'sd32767 : 16'(q_reg);
        end
        v2_mag   = (prod_reg < 0) ? (64'(-prod_reg) >> 30) : (64'(prod_reg) >> 30);
        side_l2  = acc_reg + 64'(prod_reg);
        p_mag    = (prod_reg < 0) ? 64'(-prod_reg) : 64'(prod_reg);
        move_d   = signed'((p_mag + (64'd1 << (DIR_FRAC_BITS - 1))) >> DIR_FRAC_BITS);
        if ((prod_reg < 0) != neg_reg) begin
            move_d = -move_d;
        end
        move_sum = 64'(pos_reg[idx_reg]) + move_d;
        updn_sum = (!neg_reg) ? 34'(pos_reg[1]) + 34'(dist_reg)
                              : 34'(pos_reg[1]) - 34'(dist_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser[0] == CMD_ROTATE) begin
                        state_next = ST_ROT_ANG;
                    end else begin
                        case (s_axis) inside
                            AXIS_LEFT, AXIS_RIGHT:  state_next = ST_SIDE_SQ0;
                            AXIS_UP, AXIS_DOWN:     state_next = ST_UPDN;
                            AXIS_FRONT, AXIS_BACK:  state_next = ST_MOVE_MUL;
                            default:                state_next = ST_OUT;
                        endcase
                    end
                end
            end
            ST_ROT_ANG:   state_next = ST_ROT_YMUL;
            ST_ROT_YMUL:  state_next = ST_ROT_PMUL;
            ST_ROT_PMUL:  state_next = ST_ROT_PTRIG;
            ST_ROT_PTRIG: state_next = ST_ROT_CPCY;
            ST_ROT_CPCY:  state_next = ST_ROT_V2;
            ST_ROT_V2:    state_next = ST_ROT_SQ1;
            ST_ROT_SQ1:   state_next = ST_ROT_SQ2;
            ST_ROT_SQ2:   state_next = ST_ROT_SQ3;
            ST_ROT_SQ3:   state_next = ST_SQRT;
            ST_SIDE_SQ0:  state_next = ST_SIDE_SQ1;
            ST_SIDE_SQ1:  state_next = ST_SIDE_SQ2;
            ST_SIDE_SQ2:  state_next = ST_SQRT;
            ST_SQRT: begin
                if (sq_cnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: begin
                state_next = (sq_res_reg == '0) ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                if (div_cnt_reg == DIV_CNT_W'(DIV_Q_BITS - 1)) begin
                    state_next = ST_DIV_DONE;
                end
            end
            ST_DIV_DONE: begin
                if (idx_reg != 2'd2) begin
                    state_next = ST_DIV_INIT;
                end else if (cmd_reg == CMD_ROTATE) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_MOVE_MUL;
                end
            end
            ST_MOVE_MUL:  state_next = ST_MOVE_ADD;
            ST_MOVE_ADD: begin
                state_next = (idx_reg == 2'd2) ? ST_OUT : ST_MOVE_MUL;
            end
            ST_UPDN:      state_next = ST_OUT;
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod;
        if (!aresetn) begin
            pos_reg[0]  <= '0;
            pos_reg[1]  <= '0;
            pos_reg[2]  <= 32'(64'sd10 <<< POS_FRAC_BITS);
            view_reg[0] <= '0;
            view_reg[1] <= '0;
            view_reg[2] <= 16'(-(32'sd1 <<< DIR_FRAC_BITS));
            yaw_reg     <= '0;
            pitch_reg   <= '0;
            idx_reg     <= '0;
            sq_cnt_reg  <= '0;
            div_cnt_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg  <= s_tuser[0];
                        yd_reg   <= s_tdata[15:0];
                        pd_reg   <= s_tdata[31:16];
                        dist_reg <= s_tdata[66:35];
                        idx_reg  <= '0;
                        neg_reg  <= (s_axis == AXIS_LEFT) || (s_axis == AXIS_BACK)
                                    || (s_axis == AXIS_DOWN);
                        comp_reg[0] <= 32'(view_reg[0]);
                        comp_reg[1] <= 32'(view_reg[1]);
                        comp_reg[2] <= 32'(view_reg[2]);
                    end
                end
                ST_ROT_ANG: begin
                    yaw_reg   <= yaw_new;
                    pitch_reg <= pitch_new;
                end
                ST_ROT_PMUL: begin
                    comp_reg[0] <= trig_s;
                    cy_reg      <= trig_c;
                end
                ST_ROT_PTRIG: begin
                    comp_reg[1] <= trig_s;
                    cp_reg      <= trig_c;
                end
                ST_ROT_V2: begin
                    comp_reg[2] <= (prod_reg < 0) ? 32'(v2_mag) : -32'(v2_mag);
                end
                ST_ROT_SQ1: begin
                    acc_reg <= 64'(prod_reg);
                end
                ST_ROT_SQ2: begin
                    acc_reg <= side_l2;
                end
                ST_ROT_SQ3: begin
                    sq_v_reg   <= side_l2;
                    sq_res_reg <= '0;
                    sq_bit_reg <= 64'd1 << 62;
                    sq_cnt_reg <= '0;
                end
                ST_SIDE_SQ0: begin
                    comp_reg[0] <= -32'(view_reg[2]);
                    comp_reg[1] <= '0;
                    comp_reg[2] <= 32'(view_reg[0]);
                end
                ST_SIDE_SQ1: begin
                    acc_reg <= 64'(prod_reg);
                end
                ST_SIDE_SQ2: begin
                    sq_v_reg   <= side_l2 << 16;
                    sq_res_reg <= '0;
                    sq_bit_reg <= 64'd1 << 62;
                    sq_cnt_reg <= '0;
                end
                ST_SQRT: begin
                    if (sq_ge) begin
                        sq_v_reg   <= sq_v_reg - sq_t;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                end
                ST_DIV_INIT: begin
                    n_reg       <= num_mag + (sq_res_reg >> 1);
                    dsh_reg     <= sq_res_reg << (DIV_Q_BITS - 1);
                    q_reg       <= '0;
                    div_cnt_reg <= '0;
                end
                ST_DIV: begin
                    if (div_ge) begin
                        n_reg <= n_reg - dsh_reg;
                    end
                    q_reg       <= {q_reg[DIV_Q_BITS-2:0], div_ge};
                    dsh_reg     <= dsh_reg >> 1;
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
                ST_DIV_DONE: begin
                    if (cmd_reg == CMD_ROTATE) begin
                        view_reg[idx_reg] <= div_res;
                    end else begin
                        comp_reg[idx_reg] <= 32'(div_res);
                    end
                    idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                end
                ST_MOVE_ADD: begin
                    pos_reg[idx_reg] <= sat32(move_sum);
                    idx_reg          <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                end
                ST_UPDN: begin
                    pos_reg[1] <= sat32(64'(updn_sum));
                end
                default: begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    assign m_tdata = {1'b0, pitch_reg, yaw_reg, view_reg[2], view_reg[1], view_reg[0],
                      pos_reg[2], pos_reg[1], pos_reg[0]};

endmodule

[rtl/core/fcpu_checker.sv]
// ----------------------------------------------------------------------------
// fcpu_checker
// Port-level checks for the fly camera pose update block.
// ----------------------------------------------------------------------------
module fcpu_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [175:0] m_tdata
);

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("command taken while result pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second command taken during update");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[174:160]) <= 15'sd11392)
                  && ($signed(m_tdata[174:160]) >= -15'sd11392))
        else $error("pitch outside clamp");

    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[159:144] < 16'd46080))
        else $error("yaw outside one turn");

endmodule

bind fly_camera_pose_update fcpu_checker u_fcpu_checker (.*);

[bench/tb_fly_camera_pose_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fly_camera_pose_update
// Self-checking bench for the fly camera pose block. A queue of rotate and
// translate commands feeds a stream driver with random gaps. A local pose
// model predicts every result, and a monitor with random back-pressure
// compares each returned pose field by field.
// ----------------------------------------------------------------------------
module tb_fly_camera_pose_update;
    import fcpu_pkg::*;

    localparam logic [2:0] AXIS_SPARE_A = 3'd6;
    localparam logic [2:0] AXIS_SPARE_B = 3'd7;
    localparam int         RANDOM_CMDS  = 1100;
    localparam int         CYCLE_LIMIT  = 2000000;

    typedef struct {
        logic              cmd;
        logic signed [15:0] yaw_d;
        logic signed [15:0] pitch_d;
        logic [2:0]        axis;
        logic signed [31:0] distance;
        bit                drain;
    } cmd_t;

    typedef struct {
        logic signed [31:0] px, py, pz;
        logic signed [15:0] vx, vy, vz;
        logic [15:0]        yaw;
        logic signed [14:0] pitch;
    } pose_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [175:0] m_tdata;

    cmd_t  cmd_q[$];
    pose_t pose_q[$];
    cmd_t  cur_cmd;

    int cam_pos[3];
    int view_dir[3];
    int yaw_ang;
    int pitch_ang;

    int errors = 0;
    int n_rot = 0;
    int n_axis[8] = '{default: 0};
    int n_results = 0;
    int cycles = 0;
    int send_gap = 0;
    int recv_stall = 0;
    bit send_burst = 0;
    bit recv_burst = 0;

    fly_camera_pose_update i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit [63:0] int_sqrt(input bit [63:0] v);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint round_div(input longint num, input bit [63:0] den);
        bit [63:0] mag;
        bit [63:0] q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic int clip16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic int clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    task automatic sin_cos_q30(input int ang, output longint s, output longint c);
        bit [63:0] ua, idx, u, q, r, x, x2, sn, cs;
        bit [63:0] sk[5] = '{110, 72, 42, 20, 6};
        bit [63:0] ck[6] = '{132, 90, 56, 30, 12, 2};
        longint s0, c0;
        ua = 64'((ang < 0) ? ang + TURN_UNITS : ang);
        idx = (ua * 64'(TRIG_TABLE_DEPTH)) / 64'(TURN_UNITS);
        u = 4 * idx;
        q = (u / 64'(TRIG_TABLE_DEPTH)) & 64'd3;
        r = u % 64'(TRIG_TABLE_DEPTH);
        x = (r * HALF_PI_Q30) / 64'(TRIG_TABLE_DEPTH);
        x2 = (x * x) >> 30;
        sn = ONE_Q30;
        cs = ONE_Q30;
        for (int i = 0; i < 5; i++) sn = ONE_Q30 - ((x2 * sn) >> 30) / sk[i];
        for (int i = 0; i < 6; i++) cs = ONE_Q30 - ((x2 * cs) >> 30) / ck[i];
        s0 = longint'((x * sn) >> 30);
        c0 = longint'(cs);
        case (q)
            0: begin s = s0;  c = c0;  end
            1: begin s = c0;  c = -s0; end
            2: begin s = -s0; c = -c0; end
            default: begin s = -c0; c = s0; end
        endcase
    endtask

    task automatic shift_position(input int comp[3], input longint distance, input bit neg);
        longint d;
        for (int i = 0; i < 3; i++) begin
            d = round_div(longint'(comp[i]) * distance, 64'd1 << DIR_FRAC_BITS);
            if (neg) d = -d;
            cam_pos[i] = clip32(longint'(cam_pos[i]) + d);
        end
    endtask

    task automatic apply_command(input cmd_t c);
        longint p, y, sy, cy, sp, cp, dx, dz, distance;
        longint v[3];
        bit [63:0] sum, len, m;
        int side[3];
        pose_t e;
        distance = longint'(c.distance);
        if (c.cmd == CMD_ROTATE) begin
            n_rot++;
            p = longint'(pitch_ang) + longint'(c.pitch_d);
            y = (longint'(yaw_ang) + longint'(c.yaw_d)) % TURN_UNITS;
            if (p > PITCH_LIMIT) p = PITCH_LIMIT;
            if (p < -PITCH_LIMIT) p = -PITCH_LIMIT;
            if (y < 0) y = y + TURN_UNITS;
            pitch_ang = int'(p);
            yaw_ang = int'(y);
            sin_cos_q30(yaw_ang, sy, cy);
            sin_cos_q30(pitch_ang, sp, cp);
            v[0] = sy;
            v[1] = sp;
            v[2] = -((cp * cy) / longint'(ONE_Q30));
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                m = (v[i] < 0) ? -v[i] : v[i];
                sum = sum + m * m;
            end
            len = int_sqrt(sum);
            if (len != 0)
                for (int i = 0; i < 3; i++)
                    view_dir[i] = clip16(round_div(v[i] * (64'sd1 << DIR_FRAC_BITS), len));
        end else begin
            n_axis[c.axis]++;
            if (c.axis == AXIS_LEFT || c.axis == AXIS_RIGHT) begin
                dx = view_dir[0];
                dz = view_dir[2];
                len = int_sqrt(64'(dx * dx + dz * dz) << 16);
                if (len != 0) begin
                    side[0] = clip16(round_div(-dz * (64'sd1 << (DIR_FRAC_BITS + 8)), len));
                    side[1] = 0;
                    side[2] = clip16(round_div(dx * (64'sd1 << (DIR_FRAC_BITS + 8)), len));
                    shift_position(side, distance, c.axis == AXIS_LEFT);
                end
            end else if (c.axis == AXIS_UP) begin
                cam_pos[1] = clip32(longint'(cam_pos[1]) + distance);
            end else if (c.axis == AXIS_DOWN) begin
                cam_pos[1] = clip32(longint'(cam_pos[1]) - distance);
            end else if (c.axis == AXIS_FRONT || c.axis == AXIS_BACK) begin
                shift_position(view_dir, distance, c.axis == AXIS_BACK);
            end
        end
        e.px = cam_pos[0];
        e.py = cam_pos[1];
        e.pz = cam_pos[2];
        e.vx = view_dir[0][15:0];
        e.vy = view_dir[1][15:0];
        e.vz = view_dir[2][15:0];
        e.yaw = yaw_ang[15:0];
        e.pitch = pitch_ang[14:0];
        pose_q.push_back(e);
    endtask

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        errors++;
        if (errors <= 30)
            $display("ERROR result %0d %s: got %0h, want %0h", n_results, field, got, want);
    endtask

    function automatic cmd_t make_cmd(input logic cmd, input int yd, input int pd,
                                      input logic [2:0] axis, input int distance);
        cmd_t c;
        c.cmd = cmd;
        c.yaw_d = yd[15:0];
        c.pitch_d = pd[15:0];
        c.axis = axis;
        c.distance = distance;
        c.drain = 0;
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        int yd, pd, distance;
        logic [2:0] axis;
        if ($urandom_range(0, 9) == 0) begin
            yd = $urandom_range(0, 1) ? 23040 : -23040;
            pd = $urandom_range(0, 1) ? 23040 : -23040;
        end else begin
            yd = int'($urandom_range(0, 46080)) - 23040;
            pd = int'($urandom_range(0, 6000)) - 3000;
        end
        case ($urandom_range(0, 3))
            0: distance = $urandom;
            1: distance = int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            2: distance = int'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
            default: distance = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        endcase
        axis = 3'($urandom_range(0, 7));
        return make_cmd($urandom_range(0, 9) < 4 ? CMD_ROTATE : CMD_TRANSLATE,
                        yd, pd, axis, distance);
    endfunction

    function automatic int next_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 11);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) apply_command(cur_cmd);
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (cmd_q.size() != 0 && !(cmd_q[0].drain && pose_q.size() != 0)) begin
                cur_cmd = cmd_q.pop_front();
                s_tdata <= {5'b0, cur_cmd.distance, cur_cmd.axis, cur_cmd.pitch_d,
                            cur_cmd.yaw_d};
                s_tuser <= cur_cmd.cmd;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 99) == 0) send_burst = !send_burst;
                send_gap <= next_wait(send_burst);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        pose_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (pose_q.size() == 0) begin
                report("unexpected", m_tdata[31:0], 0);
            end else begin
                e = pose_q.pop_front();
                if (m_tdata[31:0] !== e.px) report("pos_x", m_tdata[31:0], e.px);
                if (m_tdata[63:32] !== e.py) report("pos_y", m_tdata[63:32], e.py);
                if (m_tdata[95:64] !== e.pz) report("pos_z", m_tdata[95:64], e.pz);
                if (m_tdata[111:96] !== e.vx) report("view_x", m_tdata[111:96], e.vx);
                if (m_tdata[127:112] !== e.vy) report("view_y", m_tdata[127:112], e.vy);
                if (m_tdata[143:128] !== e.vz) report("view_z", m_tdata[143:128], e.vz);
                if (m_tdata[159:144] !== e.yaw) report("yaw_now", m_tdata[159:144], e.yaw);
                if (m_tdata[174:160] !== e.pitch)
                    report("pitch_now", m_tdata[174:160], e.pitch);
            end
            if ($urandom_range(0, 99) == 0) recv_burst = !recv_burst;
            recv_stall = next_wait(recv_burst);
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall = recv_stall - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, pose_q.size());
            $display("fly_camera_pose_update: mismatch");
            $finish;
        end
    end

    initial begin
        cmd_t c;
        cam_pos = '{0, 0, 10 << POS_FRAC_BITS};
        view_dir = '{0, 0, -(1 << DIR_FRAC_BITS)};
        yaw_ang = 0;
        pitch_ang = 0;

        cmd_q.push_back(make_cmd(CMD_ROTATE, 0, 0, AXIS_SPARE_B, 32'sh7fffffff));
        cmd_q.push_back(make_cmd(CMD_TRANSLATE, 23040, -23040, AXIS_FRONT, 1 << 16));
        cmd_q.push_back(make_cmd(CMD_TRANSLATE, 0, 0, AXIS_BACK, 3 << 16));
        cmd_q.push_back(make_cmd(CMD_TRANSLATE, 0, 0, AXIS_LEFT, 2 << 16));
        cmd_q.push_back(make_cmd(CMD_TRANSLATE, 0, 0, AXIS_RIGHT, -(5 << 15)));
        cmd_q.push_back(make_cmd(CMD_TRANSLATE, 0, 0, AXIS_UP, 32'sh7fffffff));
        cmd_q.push_back(make_cmd(CMD_TRANSLATE, 0, 0, AXIS_UP, 32'sh7fffffff));
        cmd_q.push_back(make_cmd(CMD_TRANSLATE, 0, 0, AXIS_DOWN, 32'sh7fffffff));
        cmd_q.push_back(make_cmd(CMD_TRANSLATE, 0, 0, AXIS_DOWN, 32'sh7fffffff));
        cmd_q.push_back(make_cmd(CMD_TRANSLATE, 0, 0, AXIS_SPARE_A, 32'sh80000000));
        cmd_q.push_back(make_cmd(CMD_TRANSLATE, 0, 0, AXIS_SPARE_B, 12345));
        cmd_q.push_back(make_cmd(CMD_ROTATE, 23040, 23040, AXIS_FRONT, -1));
        cmd_q.push_back(make_cmd(CMD_TRANSLATE, 0, 0, AXIS_FRONT, 32'sh80000000));
        cmd_q.push_back(make_cmd(CMD_TRANSLATE, 0, 0, AXIS_LEFT, 32'sh7fffffff));
        cmd_q.push_back(make_cmd(CMD_ROTATE, -23040, -23040, 3'd0, 0));
        cmd_q.push_back(make_cmd(CMD_ROTATE, -23040, -23040, 3'd0, 0));
        cmd_q.push_back(make_cmd(CMD_TRANSLATE, 0, 0, AXIS_RIGHT, 32'sh80000000));
        cmd_q.push_back(make_cmd(CMD_TRANSLATE, 0, 0, AXIS_BACK, 32'sh7fffffff));
        cmd_q.push_back(make_cmd(CMD_ROTATE, 11520, 11392, 3'd0, 0));
        cmd_q.push_back(make_cmd(CMD_TRANSLATE, -1, -1, AXIS_LEFT, 1 << 16));
        cmd_q.push_back(make_cmd(CMD_ROTATE, 1, -22784, 3'd0, 0));
        cmd_q.push_back(make_cmd(CMD_TRANSLATE, 0, 0, AXIS_FRONT, 1 << 16));
        for (int i = 0; i < RANDOM_CMDS; i++) begin
            c = random_cmd();
            c.drain = (i == 300 || i == 700);
            cmd_q.push_back(c);
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        wait (cmd_q.size() == 0 && !s_tvalid && pose_q.size() == 0);
        repeat (200) @(posedge aclk);

        $display("covered %0d rotates and translates per axis 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 n_rot, n_axis[0], n_axis[1], n_axis[2], n_axis[3],
                 n_axis[4], n_axis[5], n_axis[6], n_axis[7]);
        $display("%0d poses checked, %0d field errors", n_results, errors);
        if (errors == 0 && pose_q.size() == 0) begin
            $display("fly_camera_pose_update: match");
        end else begin
            $display("fly_camera_pose_update: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/fcpu_pkg.sv
rtl/core/fly_camera_pose_update.sv
rtl/core/fcpu_checker.sv
bench/tb_fly_camera_pose_update.sv
